// ===== rtl/npr_pkg.sv =====
// Shared types and constants for the NAND page read sequencer.
// Used by npr_emit and nand_page_read_sequencer; no dependencies.
package npr_pkg;

    // Flash page geometry
    localparam int PAGE_BYTES = 2048;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // NAND command bytes
    localparam logic [7:0] CMD_READ_SETUP   = 8'h00;
    localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

    // Input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_READY = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    // Bus operation codes carried by each result item
    typedef enum logic [2:0] {
        OP_SELECT   = 3'd0,
        OP_CMD      = 3'd1,
        OP_ADDR     = 3'd2,
        OP_STROBE   = 3'd3,
        OP_DELIVER  = 3'd4,
        OP_DESELECT = 3'd5
    } bus_op_t;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Shape of the result burst caused by one input item
    typedef enum logic [2:0] {
        BURST_SEL_DESEL  = 3'd0,  // select, deselect
        BURST_SEL_RUN    = 3'd1,  // select, command/address run
        BURST_STROBE     = 3'd2,  // read strobe
        BURST_DLV_DESEL  = 3'd3,  // deliver, deselect
        BURST_DLV_RUN    = 3'd4,  // deliver, command/address run
        BURST_DLV_STROBE = 3'd5   // deliver, read strobe
    } burst_kind_t;

    // Burst descriptor handed from the decode logic to the emitter
    typedef struct packed {
        burst_kind_t  kind;
        logic [7:0]   data_byte;
        logic [31:0]  dest_index;
        logic [15:0]  column;
        logic [23:0]  page;
    } burst_t;

    // Input item
    typedef struct packed {
        logic [1:0]   mode;
        logic [31:0]  start_address;
        logic [31:0]  byte_count;
        logic         ready_flag;
        logic [7:0]   flash_byte;
    } in_item_t;

    // Result item
    typedef struct packed {
        bus_op_t      bus_op;
        logic [7:0]   op_value;
        logic [31:0]  dest_index;
        logic         last;
    } out_item_t;

endpackage

// ===== rtl/npr_emit.sv =====
// Result emitter: holds one burst descriptor and plays out its items.
// Depends on npr_pkg.
module npr_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  npr_pkg::burst_t   burst,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output npr_pkg::out_item_t m_data
);
    import npr_pkg::*;

    burst_t     burst_reg, burst_next;
    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [2:0] last_idx;
    logic [2:0] run_pos;
    logic       last_item;
    out_item_t  res;

    // Index of the final item for each burst shape
    always_comb begin
        case (burst_reg.kind)
            BURST_STROBE:                  last_idx = 3'd0;
            BURST_SEL_RUN, BURST_DLV_RUN:  last_idx = 3'd7;
            default:                       last_idx = 3'd1;
        endcase
    end

    assign last_item = (idx_reg == last_idx);
    assign run_pos   = idx_reg - 3'd1;
    assign can_load  = !valid_reg || (m_ready && last_item);

    // Build the current result item from the descriptor and position
    always_comb begin
        res = '0;
        if (idx_reg == 3'd0) begin
            case (burst_reg.kind)
                BURST_SEL_DESEL, BURST_SEL_RUN: begin
                    res.bus_op = OP_SELECT;
                end
                BURST_STROBE: begin
                    res.bus_op = OP_STROBE;
                end
                default: begin
                    res.bus_op     = OP_DELIVER;
                    res.op_value   = burst_reg.data_byte;
                    res.dest_index = burst_reg.dest_index;
                end
            endcase
        end else begin
            case (burst_reg.kind)
                BURST_SEL_RUN, BURST_DLV_RUN: begin
                    // command 00h, column lo/hi, three page bytes, command 30h
                    case (run_pos)
                        3'd0: begin
                            res.bus_op   = OP_CMD;
                            res.op_value = CMD_READ_SETUP;
                        end
                        3'd1: begin
                            res.bus_op   = OP_ADDR;
                            res.op_value = burst_reg.column[7:0];
                        end
                        3'd2: begin
                            res.bus_op   = OP_ADDR;
                            res.op_value = burst_reg.column[15:8];
                        end
                        3'd3: begin
                            res.bus_op   = OP_ADDR;
                            res.op_value = burst_reg.page[7:0];
                        end
                        3'd4: begin
                            res.bus_op   = OP_ADDR;
                            res.op_value = burst_reg.page[15:8];
                        end
                        3'd5: begin
                            res.bus_op   = OP_ADDR;
                            res.op_value = burst_reg.page[23:16];
                        end
                        default: begin
                            res.bus_op   = OP_CMD;
                            res.op_value = CMD_READ_CONFIRM;
                        end
                    endcase
                end
                BURST_DLV_STROBE: begin
                    res.bus_op = OP_STROBE;
                end
                default: begin
                    res.bus_op = OP_DESELECT;
                end
            endcase
        end
        res.last = last_item;
    end

    assign m_valid = valid_reg;
    assign m_data  = res;

    // Descriptor load and item stepping
    always_comb begin
        burst_next = burst_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            burst_next = burst;
            idx_next   = 3'd0;
            valid_next = 1'b1;
        end else if (valid_reg && m_ready) begin
            if (last_item) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        burst_reg <= burst_next;
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/nand_page_read_sequencer.sv =====
// NAND large-page read sequencer, top level. Depends on npr_pkg and npr_emit.
// The first result of an item is registered: it is valid in the cycle after the item is accepted.
// An item causing n results (n = 0, 1, 2 or 8) holds the single burst register in npr_emit
// until its last result is taken, so one-result items flow every cycle while m_ready is high.
// Reset (aresetn, synchronous, active low): phase idle, address, count and index zero,
// no result pending.
module nand_page_read_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  npr_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output npr_pkg::out_item_t  m_data
);
    import npr_pkg::*;

    logic [31:0] read_address_reg, read_address_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] dest_position_reg, dest_position_next;
    phase_t      phase_reg, phase_next;

    logic        accept;
    logic        load;
    logic        can_load;
    burst_t      burst;
    logic [31:0] addr_inc;
    logic [31:0] left_dec;

    assign accept   = s_valid && s_ready;
    assign s_ready  = can_load;
    assign addr_inc = read_address_reg + 32'd1;
    assign left_dec = bytes_left_reg - 32'd1;

    // Decode an accepted item: state update and burst descriptor
    always_comb begin
        read_address_next  = read_address_reg;
        bytes_left_next    = bytes_left_reg;
        dest_position_next = dest_position_reg;
        phase_next         = phase_reg;
        load               = 1'b0;
        burst              = '0;
        if (accept) begin
            case (s_data.mode)
                MODE_START: begin
                    if (phase_reg != PH_WAIT && phase_reg != PH_DATA) begin
                        load               = 1'b1;
                        read_address_next  = s_data.start_address;
                        bytes_left_next    = s_data.byte_count;
                        dest_position_next = 32'd0;
                        burst.column = 16'(s_data.start_address[PAGE_SHIFT-1:0]);
                        burst.page   = 24'(s_data.start_address >> PAGE_SHIFT);
                        if (s_data.byte_count == 32'd0) begin
                            burst.kind = BURST_SEL_DESEL;
                            phase_next = PH_IDLE;
                        end else begin
                            burst.kind = BURST_SEL_RUN;
                            phase_next = PH_WAIT;
                        end
                    end
                end
                MODE_READY: begin
                    if (phase_reg == PH_WAIT && s_data.ready_flag) begin
                        load       = 1'b1;
                        burst.kind = BURST_STROBE;
                        phase_next = PH_DATA;
                    end
                end
                MODE_DATA: begin
                    if (phase_reg == PH_DATA) begin
                        load               = 1'b1;
                        burst.data_byte    = s_data.flash_byte;
                        burst.dest_index   = dest_position_reg;
                        burst.column       = 16'(addr_inc[PAGE_SHIFT-1:0]);
                        burst.page         = 24'(addr_inc >> PAGE_SHIFT);
                        dest_position_next = dest_position_reg + 32'd1;
                        read_address_next  = addr_inc;
                        bytes_left_next    = left_dec;
                        if (left_dec == 32'd0) begin
                            burst.kind = BURST_DLV_DESEL;
                            phase_next = PH_IDLE;
                        end else if (addr_inc[PAGE_SHIFT-1:0] == '0) begin
                            // page end with bytes remaining: reissue the read run
                            burst.kind = BURST_DLV_RUN;
                            phase_next = PH_WAIT;
                        end else begin
                            burst.kind = BURST_DLV_STROBE;
                        end
                    end
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_address_reg  <= 32'd0;
            bytes_left_reg    <= 32'd0;
            dest_position_reg <= 32'd0;
            phase_reg         <= PH_IDLE;
        end else begin
            read_address_reg  <= read_address_next;
            bytes_left_reg    <= bytes_left_next;
            dest_position_reg <= dest_position_next;
            phase_reg         <= phase_next;
        end
    end

    // Result playout
    npr_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst    (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef ASSERT_OFF
    // Idle means the byte count is exhausted
    a_idle_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> bytes_left_reg == 32'd0)
        else $error("idle with bytes left");

    // An active read always has bytes to go
    a_busy_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> bytes_left_reg != 32'd0)
        else $error("active read with zero bytes left");

    // An item that causes results shows a result in the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded burst not presented");

    // A delivered byte is never the final result of its item
    a_deliver_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bus_op == OP_DELIVER |-> !m_data.last)
        else $error("deliver marked last");
`endif

endmodule

// ===== tb/nand_page_read_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nand_page_read_sequencer: queue-fed driver, clocked monitor,
// built-in read-sequence predictor. Depends on npr_pkg and the sequencer RTL only.
module nand_page_read_sequencer_tb;
    import npr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 42;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t  pending_items[$];
    out_item_t expected_ops[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_armed = 1'b0;
    int        hold_count = 0;
    int        errors = 0;

    // Predicted sequencer state
    logic [31:0] flash_addr = '0;
    logic [31:0] bytes_remaining = '0;
    logic [31:0] dest_next = '0;
    phase_t      seq_phase = PH_IDLE;

    nand_page_read_sequencer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic void push_op(bus_op_t op, logic [7:0] val, logic [31:0] idx);
        out_item_t r;
        r.bus_op     = op;
        r.op_value   = val;
        r.dest_index = idx;
        r.last       = 1'b0;
        expected_ops.push_back(r);
    endfunction

    // Read setup command, column and page bytes, read confirm
    function automatic void push_read_run();
        logic [31:0] col;
        logic [31:0] pg;
        col = flash_addr % PAGE_BYTES;
        pg  = flash_addr / PAGE_BYTES;
        push_op(OP_CMD, CMD_READ_SETUP, '0);
        push_op(OP_ADDR, col[7:0], '0);
        push_op(OP_ADDR, col[15:8], '0);
        push_op(OP_ADDR, pg[7:0], '0);
        push_op(OP_ADDR, pg[15:8], '0);
        push_op(OP_ADDR, pg[23:16], '0);
        push_op(OP_CMD, CMD_READ_CONFIRM, '0);
    endfunction

    function automatic void predict_ops(in_item_t it);
        int first;
        first = expected_ops.size();
        case (it.mode)
            MODE_START: begin
                if (seq_phase == PH_IDLE) begin
                    flash_addr      = it.start_address;
                    bytes_remaining = it.byte_count;
                    dest_next       = '0;
                    push_op(OP_SELECT, '0, '0);
                    if (bytes_remaining == 0) begin
                        push_op(OP_DESELECT, '0, '0);
                    end else begin
                        push_read_run();
                        seq_phase = PH_WAIT;
                    end
                end
            end
            MODE_READY: begin
                if (seq_phase == PH_WAIT && it.ready_flag) begin
                    push_op(OP_STROBE, '0, '0);
                    seq_phase = PH_DATA;
                end
            end
            MODE_DATA: begin
                if (seq_phase == PH_DATA) begin
                    push_op(OP_DELIVER, it.flash_byte, dest_next);
                    dest_next       = dest_next + 1;
                    flash_addr      = flash_addr + 1;
                    bytes_remaining = bytes_remaining - 1;
                    if (bytes_remaining == 0) begin
                        push_op(OP_DESELECT, '0, '0);
                        seq_phase = PH_IDLE;
                    end else if (flash_addr % PAGE_BYTES == 0) begin
                        push_read_run();
                        seq_phase = PH_WAIT;
                    end else begin
                        push_op(OP_STROBE, '0, '0);
                    end
                end
            end
            default: ;
        endcase
        if (expected_ops.size() > first)
            expected_ops[expected_ops.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    // ---------------- driver and receiver ----------------

    // Offer the next pending item once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_armed && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !(hold_armed && hold_count < HOLD_CYCLES) &&
                       ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_ops(s_data);
            if (m_valid && m_ready) begin
                if (expected_ops.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: bus_op %0d value %02h",
                                              int'(m_data.bus_op), m_data.op_value));
                end else begin
                    want = expected_ops.pop_front();
                    if (m_data.bus_op !== want.bus_op)
                        report_mismatch($sformatf("bus_op %0d, expected %0d",
                                                  int'(m_data.bus_op), int'(want.bus_op)));
                    if (m_data.op_value !== want.op_value)
                        report_mismatch($sformatf("op_value %02h, expected %02h",
                                                  m_data.op_value, want.op_value));
                    if (m_data.dest_index !== want.dest_index)
                        report_mismatch($sformatf("dest_index %0h, expected %0h",
                                                  m_data.dest_index, want.dest_index));
                    if (m_data.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_data.last, want.last));
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // All fields random so that unused fields toggle too
    function automatic in_item_t make_item(logic [1:0] mode);
        in_item_t it;
        it.mode          = mode;
        it.start_address = $urandom;
        it.byte_count    = $urandom;
        it.ready_flag    = 1'($urandom_range(1));
        it.flash_byte    = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic void send_start(logic [31:0] addr, logic [31:0] cnt);
        in_item_t it;
        it = make_item(MODE_START);
        it.start_address = addr;
        it.byte_count    = cnt;
        pending_items.push_back(it);
    endfunction

    function automatic void send_ready(bit flag);
        in_item_t it;
        it = make_item(MODE_READY);
        it.ready_flag = flag;
        pending_items.push_back(it);
    endfunction

    function automatic void send_byte(logic [7:0] b);
        in_item_t it;
        it = make_item(MODE_DATA);
        it.flash_byte = b;
        pending_items.push_back(it);
    endfunction

    // An item the block must ignore in the given phase
    function automatic void send_noise(phase_t ph);
        int pick;
        pick = $urandom_range(2);
        case (ph)
            PH_IDLE: begin
                if (pick == 0)      send_ready(1'($urandom_range(1)));
                else if (pick == 1) send_byte(8'($urandom_range(255)));
                else                pending_items.push_back(make_item(MODE_UNUSED));
            end
            PH_WAIT: begin
                if (pick == 0)      pending_items.push_back(make_item(MODE_START));
                else if (pick == 1) send_byte(8'($urandom_range(255)));
                else                pending_items.push_back(make_item(MODE_UNUSED));
            end
            default: begin
                if (pick == 0)      pending_items.push_back(make_item(MODE_START));
                else if (pick == 1) send_ready(1'($urandom_range(1)));
                else                pending_items.push_back(make_item(MODE_UNUSED));
            end
        endcase
    endfunction

    // Well-formed read: start, then per page ready handshake and data bytes
    function automatic void send_read(logic [31:0] addr, logic [31:0] len, int noise_pct);
        logic [31:0] a;
        logic [31:0] left;
        send_start(addr, len);
        a    = addr;
        left = len;
        while (left != 0) begin
            if ($urandom_range(99) < noise_pct) send_noise(PH_WAIT);
            if ($urandom_range(3) == 0) send_ready(1'b0);
            send_ready(1'b1);
            do begin
                if ($urandom_range(99) < noise_pct) send_noise(PH_DATA);
                send_byte(8'($urandom_range(255)));
                a    = a + 1;
                left = left - 1;
            end while (left != 0 && a % PAGE_BYTES != 0);
        end
    endfunction

    function automatic void fill_phase(int n);
        int base;
        logic [31:0] addr;
        logic [31:0] len;
        base = pending_items.size();
        while (pending_items.size() - base < n) begin
            if ($urandom_range(9) < 2) begin
                send_noise(PH_IDLE);
            end else begin
                addr = $urandom;
                // Often start just short of a page end
                if ($urandom_range(2) == 0)
                    addr = addr - addr % PAGE_BYTES + PAGE_BYTES - 1 - $urandom_range(6);
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = $urandom_range(40, 13);
                    default: len = $urandom_range(12, 1);
                endcase
                send_read(addr, len, 15);
            end
        end
    endfunction

    // Sender pause: everything offered, taken and answered
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_ops.size() != 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero length at the top address, ignored items while idle
        send_start(32'hFFFF_FFFF, 32'h0);
        send_ready(1'b1);
        send_byte(8'hFF);
        pending_items.push_back(make_item(MODE_UNUSED));
        // Address wrap through zero, not-ready sample, wrong-phase items
        send_start(32'hFFFF_FFFE, 32'd3);
        send_ready(1'b0);
        send_byte(8'h00);
        send_ready(1'b1);
        send_start(32'h0, 32'hFFFF_FFFF);
        pending_items.push_back(make_item(MODE_UNUSED));
        send_byte(8'hFF);
        send_byte(8'h00);
        send_ready(1'b1);
        send_byte(8'hA5);
        // Ordinary page end, then the smallest read from address zero
        send_read(32'h0000_07FF, 32'd2, 0);
        send_read(32'h0, 32'd1, 0);
        wait_drained();

        // Random phases with different idling
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; hold_armed = 1'b1; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            fill_phase(ITEMS_PER_PHASE);
            wait_drained();
        end

        // Full byte count from near the top: wraps through page zero, never finishes
        send_start(32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send_ready(1'b1);
        repeat (4) send_byte(8'($urandom_range(255)));
        send_ready(1'b1);
        repeat (2) send_byte(8'($urandom_range(255)));
        wait_drained();

        repeat (8) @(posedge aclk);
        if (errors == 0 && expected_ops.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
